// ===== sv/xsfb_pkg.sv =====
// Package for the XOR sprite framebuffer: screen geometry, operation codes
// and the command word that passes from the controller to the datapath.
// Depends on nothing; every other file of the block takes names from here.
package xsfb_pkg;

   // Screen geometry. Pixel rows are always 64 bits wide, bit 63 being column 0.
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int ROW_BITS      = 64;

   // Width of a row index, and of the start row plus offset before clipping.
   localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
   localparam int OFFS_W    = 4;
   localparam int ROW_SUM_W = ((ROW_W > OFFS_W) ? ROW_W : OFFS_W) + 1;
   localparam int COL_W     = $clog2(SCREEN_WIDTH);

   // Columns that lie on the screen; the rest are never drawn.
   localparam logic [ROW_BITS-1:0] COL_MASK =
      ~({ROW_BITS{1'b1}} >> SCREEN_WIDTH);

   // Operation codes; the fourth code does nothing to the screen.
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2
   } xsfb_op_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } xsfb_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the request word
      logic fetch;     // read the addressed row from memory
      logic execute;   // modify, write back and give the result word
   } xsfb_cmd_type;

endpackage

// ===== sv/xor_sprite_framebuffer.sv =====
// Top level of the XOR sprite framebuffer: joins the controller and the datapath.
// Depends on xsfb_pkg, xsfb_ctrl and xsfb_datapath.
//
//   Channel    Ports                                      Handshake
//   request    req_op, req_base_x ... req_last_row        start high, busy low
//   result     rsp_collision, rsp_row_bits, rsp_sprite_done   rsp_valid, one cycle
//
// Every word passes through three steps: capture, row fetch from the single-port row
// memory, then modify and write back. The result strobe comes in the cycle after
// the write-back, and a new word may already be accepted at the end of that cycle.
// A clear resets the per-row valid bits at once, so it takes no longer than a draw.
// Synchronous reset turns every pixel off and clears the collision flag.
// The receiver cannot stall: each result is shown for exactly one cycle.
module xor_sprite_framebuffer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_base_x,
   input  logic [7:0]                      req_base_y,
   input  logic [3:0]                      req_row_offset,
   input  logic [7:0]                      req_sprite_byte,
   input  logic                            req_first_row,
   input  logic                            req_last_row,
   output logic                            rsp_valid,
   output logic                            rsp_collision,
   output logic [xsfb_pkg::ROW_BITS-1:0]   rsp_row_bits,
   output logic                            rsp_sprite_done
);

   xsfb_pkg::xsfb_cmd_type cmd;

   // Sequencer.
   xsfb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Row memory and pixel logic.
   xsfb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_base_x      (req_base_x),
      .req_base_y      (req_base_y),
      .req_row_offset  (req_row_offset),
      .req_sprite_byte (req_sprite_byte),
      .req_first_row   (req_first_row),
      .req_last_row    (req_last_row),
      .rsp_valid       (rsp_valid),
      .rsp_collision   (rsp_collision),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_sprite_done (rsp_sprite_done)
   );

endmodule

// ===== sv/xsfb_ctrl.sv =====
// Controller of the XOR sprite framebuffer: a three-state sequencer that
// steps each request word through capture, row fetch and execute.
// Depends on xsfb_pkg.
module xsfb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output xsfb_pkg::xsfb_cmd_type cmd
);

   xsfb_pkg::xsfb_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xsfb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      unique case (state_ff)
         xsfb_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = xsfb_pkg::ST_FETCH;
            end
         end
         xsfb_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = xsfb_pkg::ST_EXEC;
         end
         xsfb_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = xsfb_pkg::ST_IDLE;
         end
         default: begin
            state_in = xsfb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/xsfb_datapath.sv =====
// Datapath of the XOR sprite framebuffer: request registers, the row memory
// with its per-row valid bits, the XOR and collision logic and the result word.
// Depends on xsfb_pkg.
module xsfb_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  xsfb_pkg::xsfb_cmd_type           cmd,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_base_x,
   input  logic [7:0]                      req_base_y,
   input  logic [3:0]                      req_row_offset,
   input  logic [7:0]                      req_sprite_byte,
   input  logic                            req_first_row,
   input  logic                            req_last_row,
   output logic                            rsp_valid,
   output logic                            rsp_collision,
   output logic [xsfb_pkg::ROW_BITS-1:0]   rsp_row_bits,
   output logic                            rsp_sprite_done
);

   localparam int H     = xsfb_pkg::SCREEN_HEIGHT;
   localparam int RW    = xsfb_pkg::ROW_W;
   localparam int SW    = xsfb_pkg::ROW_SUM_W;
   localparam int CW    = xsfb_pkg::COL_W;
   localparam int BITS  = xsfb_pkg::ROW_BITS;

   // Captured request word.
   logic [1:0]      op_ff;
   logic [CW-1:0]   x0_ff;
   logic [RW-1:0]   row_idx_ff;
   logic            row_ok_ff;
   logic [7:0]      sprite_ff;
   logic            first_ff;
   logic            last_ff;

   // Row memory and the row read from it.
   logic [BITS-1:0] row_mem [H];
   logic [H-1:0]    valid_ff;
   logic [BITS-1:0] rd_data_ff;
   logic            rd_valid_ff;

   // Collision flag and result word.
   logic            hit_ff, hit_in;
   logic            rsp_valid_ff;
   logic            rsp_collision_ff;
   logic [BITS-1:0] rsp_row_bits_ff;
   logic            rsp_sprite_done_ff;

   // Address decode of the incoming word.
   logic [RW-1:0]   y0;
   logic [SW-1:0]   row_sum;
   logic            is_draw_in;
   logic            row_ok_in;
   logic [RW-1:0]   row_idx_in;
   logic [CW-1:0]   x0_in;

   // Execute logic.
   logic [BITS-1:0] old_row;
   logic [BITS-1:0] pix_mask;
   logic [BITS-1:0] new_row;
   logic            collide;
   logic            do_write;

   always_comb begin
      y0         = RW'(req_base_y % xsfb_pkg::SCREEN_HEIGHT);
      x0_in      = CW'(req_base_x % xsfb_pkg::SCREEN_WIDTH);
      row_sum    = SW'(y0) + SW'(req_row_offset);
      is_draw_in = (req_op == xsfb_pkg::OP_DRAW);
      // A drawn row past the bottom edge is clipped; a read row always wraps.
      if (is_draw_in) begin
         row_ok_in  = (row_sum < SW'(H));
         row_idx_in = row_ok_in ? row_sum[RW-1:0] : '0;
      end else begin
         row_ok_in  = 1'b1;
         row_idx_in = y0;
      end
   end

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         x0_ff      <= x0_in;
         row_idx_ff <= row_idx_in;
         row_ok_ff  <= row_ok_in;
         sprite_ff  <= req_sprite_byte;
         first_ff   <= req_first_row;
         last_ff    <= req_last_row;
      end
   end

   // Memory read, registered.
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_data_ff  <= row_mem[row_idx_ff];
         rd_valid_ff <= valid_ff[row_idx_ff];
      end
   end

   // A row never written since reset or the last clear reads as all off.
   always_comb begin
      old_row  = rd_valid_ff ? rd_data_ff : '0;
      pix_mask = ({sprite_ff, {(BITS-8){1'b0}}} >> x0_ff) & xsfb_pkg::COL_MASK;
      if (!row_ok_ff) begin
         pix_mask = '0;
      end
      new_row  = old_row ^ pix_mask;
      collide  = |(old_row & pix_mask);
      do_write = cmd.execute && (op_ff == xsfb_pkg::OP_DRAW) && row_ok_ff;
      hit_in   = hit_ff;
      if (op_ff == xsfb_pkg::OP_DRAW) begin
         hit_in = (first_ff ? 1'b0 : hit_ff) | collide;
      end
   end

   // Row write-back.
   always_ff @(posedge clock) begin
      if (do_write) begin
         row_mem[row_idx_ff] <= new_row;
      end
   end

   // Valid bits and collision flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (cmd.execute) begin
         hit_ff <= hit_in;
         if (op_ff == xsfb_pkg::OP_CLEAR) begin
            valid_ff <= '0;
         end else if (do_write) begin
            valid_ff[row_idx_ff] <= 1'b1;
         end
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_collision_ff   <= hit_in;
         rsp_row_bits_ff    <= (op_ff == xsfb_pkg::OP_READ) ? old_row : '0;
         rsp_sprite_done_ff <= (op_ff == xsfb_pkg::OP_DRAW) && last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_collision   = rsp_collision_ff;
   assign rsp_row_bits    = rsp_row_bits_ff;
   assign rsp_sprite_done = rsp_sprite_done_ff;

endmodule

// ===== sv/xsfb_checker.sv =====
// Port checker for the XOR sprite framebuffer, with the bind that attaches it.
// Depends on xsfb_pkg and the top level xor_sprite_framebuffer.
module xsfb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [xsfb_pkg::ROW_BITS-1:0]   rsp_row_bits,
   input logic                            rsp_sprite_done
);

   // Every accepted word gives its result word once it has passed the fetch and execute states.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("result word missing three cycles after acceptance");

   // An accepted word keeps the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a word");

   // Result strobes never come back to back.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // A result word is either a read row or a draw answer, never both.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_sprite_done || (rsp_row_bits == '0)))
      else $error("row data and sprite end given together");

endmodule

bind xor_sprite_framebuffer xsfb_checker u_xsfb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_row_bits    (rsp_row_bits),
   .rsp_sprite_done (rsp_sprite_done)
);
